/* design/scdg_pkg.sv */
// Shared types, codes and the sine table for the sine commutation duty generator.
// No dependencies; imported by the top level.
`default_nettype none

package scdg_pkg;

  typedef struct packed {
    logic        command;
    logic [1:0]  phase_select;
    logic [15:0] magnitude;
  } req_item_t;

  typedef struct packed {
    logic [15:0]        duty;
    logic signed [15:0] sine_value;
  } rsp_item_t;

  // One stored entry per motor phase.
  typedef struct packed {
    logic [7:0]  slew_index;
    logic [23:0] accumulator;
    logic [15:0] cycle_count;
  } phase_state_t;

  typedef enum logic [2:0] {
    CFG_PHASE_STEP   = 3'd0,
    CFG_MID_DUTY     = 3'd1,
    CFG_LOW_DUTY     = 3'd2,
    CFG_HIGH_DUTY    = 3'd3,
    CFG_CYCLE_LENGTH = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FRAC,
    ST_SQUARE,
    ST_PROD,
    ST_ROUND,
    ST_SCALE,
    ST_TRUNC,
    ST_CLAMP
  } state_t;

  localparam logic        CMD_SLEW  = 1'b0;
  localparam logic        CMD_MICRO = 1'b1;

  // 2*pi in Q3.30, and 1.0 in Q1.30.
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'd1 << 30;

  localparam logic [15:0] QUARTER_SINE [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32767
  };

  // Full-cycle Q1.15 sine from the quarter wave, using mirror and sign symmetry.
  function automatic logic signed [15:0] rom_sine(input logic [7:0] i);
    logic [6:0]  h;
    logic [7:0]  m;
    logic [15:0] v;
    h = i[6:0];
    m = 8'd128 - {1'b0, h};
    v = (h <= 7'd64) ? QUARTER_SINE[h] : QUARTER_SINE[m[6:0]];
    return i[7] ? -$signed(v) : $signed(v);
  endfunction

endpackage

`default_nettype wire

/* design/scdg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module scdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/sine_commutation_duty_generator_top.sv */
// Top level of the sine commutation duty generator: config registers, sequencer
// and datapath. Depends on scdg_pkg and scdg_ram.
`default_nettype none

// Usage
//   req channel: one item asks for a duty value for one phase, either a slew
//   table step (command 0) or an interpolated micro-step (command 1).
//   rsp channel: one item back per request, the clamped duty and the sine used.
//   cfg channel: register writes, always ready; write only while idle.
// Sequencing
//   A slew item walks ST_READ, ST_SCALE, ST_TRUNC and ST_CLAMP; a micro-step
//   item walks ST_READ, ST_FRAC, ST_SQUARE, ST_PROD, ST_ROUND, ST_SCALE,
//   ST_TRUNC and ST_CLAMP, the chain of multiplies (fraction scaling, square,
//   angle-addition products, amplitude scaling). A new request is taken only
//   once the sequencer is back in ST_IDLE, so items do not overlap.
//   Per-phase state lives in a small RAM read at acceptance and written back
//   in the next cycle, before another request can enter.
// Reset
//   rst clears the config registers to their defaults and marks every phase
//   entry as zero through per-phase valid bits; no clearing pass is needed.
// Stalls
//   A finished item waits in the output register; a new request is accepted
//   while it waits, and the sequencer holds at its last step until the slot frees.

module sine_commutation_duty_generator_top #(
  parameter int SLEW_STEPS  = 256,
  parameter int PHASE_COUNT = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire scdg_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output scdg_pkg::rsp_item_t      rsp,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [23:0]         cfg_data
);

  import scdg_pkg::*;

  localparam int PW = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam int SW = $bits(phase_state_t);

  // Configuration registers.
  logic [23:0] phase_step;
  logic [15:0] mid_duty;
  logic [15:0] low_duty;
  logic [15:0] high_duty;
  logic [15:0] cycle_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      mid_duty     <= 16'd32768;
      low_duty     <= 16'd0;
      high_duty    <= 16'd65535;
      cycle_length <= 16'd65535;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:   phase_step   <= cfg_data;
        CFG_MID_DUTY:     mid_duty     <= cfg_data[15:0];
        CFG_LOW_DUTY:     low_duty     <= cfg_data[15:0];
        CFG_HIGH_DUTY:    high_duty    <= cfg_data[15:0];
        CFG_CYCLE_LENGTH: cycle_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Slew index to ROM index map, fixed at elaboration.
  logic [7:0] slew_map [256];
  for (genvar g = 0; g < 256; g++) begin : g_slew_map
    assign slew_map[g] = 8'((g * 256) / SLEW_STEPS);
  end

  state_t state, state_next;
  logic   accept;
  logic   mem_re;
  logic   mem_we;
  logic   load_out;

  // Phase select folded into range; the value is at most 3.
  logic [1:0]    ph_fold;
  logic [PW-1:0] ph_in;

  always_comb begin
    ph_fold = req.phase_select;
    for (int k = 0; k < 3; k++) begin
      if (int'(ph_fold) >= PHASE_COUNT) begin
        ph_fold = ph_fold - 2'(PHASE_COUNT);
      end
    end
    ph_in = PW'(ph_fold);
  end

  // Item registers.
  logic          cmd_r;
  logic [PW-1:0] ph_r;
  logic [15:0]   mag_r;
  logic          valid_r;

  // Per-phase state memory with reset-cleared valid bits.
  logic [PHASE_COUNT-1:0] entry_valid;
  logic [SW-1:0]          mem_rdata;
  phase_state_t           entry;
  phase_state_t           entry_wr;

  scdg_ram #(
    .WIDTH (SW),
    .DEPTH (PHASE_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ph_r),
    .wdata (entry_wr),
    .re    (mem_re),
    .raddr (ph_in),
    .rdata (mem_rdata)
  );

  // Datapath registers.
  logic [23:0]        acc_r;
  logic [24:0]        fr_r;
  logic [30:0]        fcos_r;
  logic signed [15:0] rom_s_r;
  logic signed [15:0] rom_c_r;
  logic signed [46:0] p1_r;
  logic signed [41:0] p2_r;
  logic signed [15:0] sine_r;
  logic signed [32:0] mprod_r;
  logic signed [18:0] d_r;

  assign entry = valid_r ? phase_state_t'(mem_rdata) : '0;

  // Read-modify-write of the phase entry.
  logic [23:0] acc_sum;
  logic [16:0] cnt_inc;
  logic        cycle_wrap;
  logic [8:0]  slew_inc;
  logic [7:0]  slew_next;

  always_comb begin
    acc_sum    = entry.accumulator + phase_step;
    cnt_inc    = {1'b0, entry.cycle_count} + 17'd1;
    cycle_wrap = cnt_inc >= {1'b0, cycle_length};
    slew_inc   = {1'b0, entry.slew_index} + 9'd1;
    slew_next  = (slew_inc >= 9'(SLEW_STEPS)) ? 8'd0 : slew_inc[7:0];
    entry_wr   = entry;
    if (cmd_r == CMD_MICRO) begin
      entry_wr.accumulator = cycle_wrap ? 24'd0 : acc_sum;
      entry_wr.cycle_count = cycle_wrap ? 16'd0 : cnt_inc[15:0];
    end else begin
      entry_wr.slew_index = slew_next;
    end
  end

  // Arithmetic between the stage registers.
  logic [48:0]        fr_prod;
  logic [49:0]        fr_sq;
  logic signed [46:0] sum;
  logic signed [46:0] sum_rnd;
  logic signed [16:0] q;
  logic signed [15:0] q_sat;
  logic signed [33:0] t;
  logic signed [33:0] t_bias;
  logic [15:0]        duty_hi;
  logic [15:0]        duty_clamped;

  always_comb begin
    fr_prod = 49'(acc_r[15:0]) * 49'(TWO_PI_Q30);
    fr_sq   = 50'(fr_r) * 50'(fr_r);
    sum     = p1_r + 47'(p2_r);
    sum_rnd = sum + 47'sd536870912;
    q       = sum_rnd[46:30];
    if (q > 17'sd32767) begin
      q_sat = 16'sd32767;
    end else if (q < -17'sd32768) begin
      q_sat = -16'sd32768;
    end else begin
      q_sat = q[15:0];
    end
    // Truncation toward zero of t / 2^15.
    t      = $signed({3'b000, mid_duty, 15'd0}) + 34'(mprod_r);
    t_bias = t + (t[33] ? 34'sd32767 : 34'sd0);
    // High clamp first, then the low clamp acts on the high-clamped value.
    if (d_r > $signed({3'b000, high_duty})) begin
      duty_hi = high_duty;
    end else begin
      duty_hi = d_r[15:0];
    end
    if ((d_r < $signed({3'b000, low_duty})) || (duty_hi < low_duty)) begin
      duty_clamped = low_duty;
    end else begin
      duty_clamped = duty_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= req.command;
      ph_r    <= ph_in;
      mag_r   <= req.magnitude;
      valid_r <= entry_valid[ph_in];
    end
    unique case (state)
      ST_READ: begin
        acc_r <= acc_sum;
        if (cmd_r == CMD_SLEW) begin
          sine_r <= rom_sine(slew_map[entry.slew_index]);
        end
      end
      ST_FRAC: begin
        fr_r <= fr_prod[48:24];
      end
      ST_SQUARE: begin
        fcos_r  <= ONE_Q30 - 31'(fr_sq[49:31]);
        rom_s_r <= rom_sine(acc_r[23:16]);
        rom_c_r <= rom_sine(acc_r[23:16] + 8'd64);
      end
      ST_PROD: begin
        p1_r <= rom_s_r * $signed({1'b0, fcos_r});
        p2_r <= rom_c_r * $signed({1'b0, fr_r});
      end
      ST_ROUND: begin
        sine_r <= q_sat;
      end
      ST_SCALE: begin
        mprod_r <= $signed({1'b0, mag_r}) * sine_r;
      end
      ST_TRUNC: begin
        d_r <= t_bias[33:15];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[ph_r] <= 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_READ;
      ST_READ:   state_next = (cmd_r == CMD_MICRO) ? ST_FRAC : ST_SCALE;
      ST_FRAC:   state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_PROD;
      ST_PROD:   state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_TRUNC;
      ST_TRUNC:  state_next = ST_CLAMP;
      ST_CLAMP:  if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:  req_ready = 1'b1;
      ST_READ:  mem_we    = 1'b1;
      ST_CLAMP: load_out  = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  assign accept = req_valid && req_ready;
  assign mem_re = accept;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.duty       <= duty_clamped;
      rsp.sine_value <= sine_r;
    end
  end

  // The phase entry is read at acceptance and used in the very next cycle.
  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted item did not move to the entry read step");

  // Write-back happens once per item, in the cycle after the read.
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> $past(accept))
    else $error("phase entry written without a preceding read");

  // The stored slew index never leaves the table.
  a_slew_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, entry_wr.slew_index} < 9'(SLEW_STEPS)))
    else $error("slew index written out of range");

  // A result is loaded only from the last step, and never over a waiting one.
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state == ST_CLAMP) && (!rsp_valid || rsp_ready))
    else $error("result loaded while the output slot was busy");

endmodule

`default_nettype wire
